// ===== sv/tcce_pkg.sv =====
// Package for the text console cell engine: screen geometry, field widths,
// the result record and the linear position helper. No dependencies.
package tcce_pkg;

    // Screen geometry.
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int SCROLL_LEN = CELL_COUNT - COLUMNS;

    // Field widths fixed by the interface.
    localparam int FUNC_W = 2;
    localparam int BYTE_W = 8;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int POS_W  = 11;
    localparam int ADDR_W = $clog2(CELL_COUNT);

    localparam logic [BYTE_W-1:0] NEWLINE_CODE  = 8'd10;
    localparam logic [BYTE_W-1:0] DEFAULT_ATTR  = 8'h07;

    // Request kinds carried on s_tuser.
    typedef enum logic [FUNC_W-1:0] {
        FN_APPEND     = 2'd0,
        FN_SET_CELL   = 2'd1,
        FN_READ_CELL  = 2'd2,
        FN_SET_CURSOR = 2'd3
    } func_t;

    // One result item.
    typedef struct packed {
        logic              upd;
        logic [POS_W-1:0]  pos;
        logic [BYTE_W-1:0] ch;
        logic [BYTE_W-1:0] at;
    } result_t;

    // Linear position column + row * COLUMNS, kept to POS_W bits.
    function automatic logic [POS_W-1:0] lin_pos(input logic [COL_W-1:0] c,
                                                 input logic [ROW_W-1:0] r);
        logic [POS_W-1:0] prod;
        prod = POS_W'(r) * POS_W'(COLUMNS);
        return prod + POS_W'(c);
    endfunction

endpackage

// ===== sv/text_console_cell_engine.sv =====
// Text console cell engine: cell memory, cursor, scroll sequencer and
// stream ports. Depends on tcce_pkg.
//
//  channel | direction | handshake         | payload
//  s_      | in        | s_tvalid/s_tready | s_tuser: func; s_tdata: char, attr, col, row
//  m_      | out       | m_tvalid/m_tready | m_tuser: cursor_update; m_tdata: pos, char, attr
//  cfg_    | in        | cfg_valid/cfg_ready | cfg_data: default attribute
//
// A request is accepted (address and memory read issue), then executed
// (memory write, cursor update, result). An append that must scroll first
// makes 1920 pipelined cell copies through the single memory read port,
// drains the last copy and writes 80 blank cells into the last row.
// After reset a clearing pass writes zero to all 2000 cells, one per cycle;
// no request is accepted during it, configuration writes are taken.
// A result waiting on m_ does not block the next request from being taken.
module text_console_cell_engine
    import tcce_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // char_code[7:0], attribute[15:8], column[22:16],
                                   // row[27:23], zero fill
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // cursor_position[10:0], cell_char[18:11],
                                   // cell_attr[26:19], zero fill
    output logic [0:0]  m_tuser,   // cursor_update[0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_SCROLL, ST_BLANK, ST_EXEC, ST_HOLD
    } state_t;

    state_t            state_reg;
    logic [ADDR_W-1:0] cnt_reg;
    logic [COL_W-1:0]  cur_col_reg;
    logic [ROW_W-1:0]  cur_row_reg;
    logic [BYTE_W-1:0] def_attr_reg;

    // Latched request.
    func_t             func_reg;
    logic [BYTE_W-1:0] char_reg;
    logic [BYTE_W-1:0] attr_reg;
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic              inside_reg;

    // Scroll copy pipeline: a read issued last cycle is written this cycle.
    logic              scr_wvalid_reg;
    logic [ADDR_W-1:0] scr_waddr_reg;

    // Output register and a holding slot for a result finished while m_ is full.
    result_t           out_reg;
    logic              out_valid_reg;
    result_t           pend_reg;

    // Cell memory: character in the upper byte, attribute in the lower.
    logic [2*BYTE_W-1:0] mem [CELL_COUNT];
    logic [2*BYTE_W-1:0] rd_data_reg;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [2*BYTE_W-1:0] mem_wdata;
    logic [ADDR_W-1:0]   mem_raddr;

    // Input field decode.
    func_t             in_func;
    logic [BYTE_W-1:0] in_char;
    logic [BYTE_W-1:0] in_attr;
    logic [COL_W-1:0]  in_col;
    logic [ROW_W-1:0]  in_row;
    logic              in_inside;
    logic [ADDR_W-1:0] in_addr;
    logic              s_acc;
    logic              out_free;
    logic              out_load;

    assign in_func   = func_t'(s_tuser);
    assign in_char   = s_tdata[7:0];
    assign in_attr   = s_tdata[15:8];
    assign in_col    = s_tdata[22:16];
    assign in_row    = s_tdata[27:23];
    assign in_inside = (32'(in_col) < COLUMNS) && (32'(in_row) < ROWS);
    assign in_addr   = in_inside ? ADDR_W'(lin_pos(in_col, in_row)) : '0;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign out_load  = (state_reg == ST_EXEC || state_reg == ST_HOLD) && out_free;
    assign cfg_ready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.upd;
    assign m_tdata  = {5'd0, out_reg.at, out_reg.ch, out_reg.pos};

    // Execute step: new cursor and the result of the latched request.
    logic [COL_W-1:0]  nx_col;
    logic [ROW_W-1:0]  nx_row;
    logic [COL_W-1:0]  inc_col;
    logic              is_newline;
    result_t           res;

    always_comb begin
        inc_col    = cur_col_reg + COL_W'(1);
        is_newline = (char_reg == NEWLINE_CODE);
        nx_col     = cur_col_reg;
        nx_row     = cur_row_reg;
        case (func_reg)
            FN_APPEND: begin
                if (is_newline) begin
                    nx_col = '0;
                    if (32'(cur_row_reg) < ROWS) begin
                        nx_row = cur_row_reg + ROW_W'(1);
                    end
                end else if (32'(inc_col) >= COLUMNS) begin
                    nx_col = '0;
                    nx_row = cur_row_reg + ROW_W'(1);
                end else begin
                    nx_col = inc_col;
                end
            end
            FN_SET_CURSOR: begin
                nx_col = (32'(col_reg) < COLUMNS) ? col_reg : COL_W'(COLUMNS - 1);
                nx_row = (32'(row_reg) < ROWS) ? row_reg : ROW_W'(ROWS - 1);
            end
            default: ;
        endcase

        res     = '0;
        res.pos = lin_pos(nx_col, nx_row);
        case (func_reg)
            FN_APPEND:     res.upd = !is_newline;
            FN_SET_CURSOR: res.upd = 1'b1;
            default:       res.upd = 1'b0;
        endcase
        if (!res.upd) begin
            res.pos = '0;
        end
        if (func_reg == FN_READ_CELL && inside_reg) begin
            res.ch = rd_data_reg[2*BYTE_W-1:BYTE_W];
            res.at = rd_data_reg[BYTE_W-1:0];
        end
    end

    // Memory port control.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = cnt_reg;
        mem_wdata = '0;
        mem_raddr = in_addr;
        if (state_reg == ST_SCROLL) begin
            mem_raddr = cnt_reg + ADDR_W'(COLUMNS);
        end
        if (scr_wvalid_reg) begin
            mem_we    = 1'b1;
            mem_waddr = scr_waddr_reg;
            mem_wdata = rd_data_reg;
        end else begin
            unique case (state_reg)
                ST_CLEAR: begin
                    mem_we = 1'b1;
                end
                ST_BLANK: begin
                    mem_we    = 1'b1;
                    mem_wdata = {{BYTE_W{1'b0}}, def_attr_reg};
                end
                ST_EXEC: begin
                    if (func_reg == FN_APPEND && !is_newline) begin
                        mem_we    = 1'b1;
                        mem_waddr = ADDR_W'(lin_pos(cur_col_reg, cur_row_reg));
                        mem_wdata = {char_reg, def_attr_reg};
                    end else if (func_reg == FN_SET_CELL && inside_reg) begin
                        mem_we    = 1'b1;
                        mem_waddr = addr_reg;
                        mem_wdata = {char_reg, attr_reg};
                    end
                end
                default: ;
            endcase
        end
    end

    // Synchronous memory, one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    // Request latch, no reset needed.
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            func_reg   <= in_func;
            char_reg   <= in_char;
            attr_reg   <= in_attr;
            col_reg    <= in_col;
            row_reg    <= in_row;
            addr_reg   <= in_addr;
            inside_reg <= in_inside;
        end
    end

    // Sequencer, cursor, configuration and output registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            cnt_reg        <= '0;
            cur_col_reg    <= '0;
            cur_row_reg    <= '0;
            def_attr_reg   <= DEFAULT_ATTR;
            scr_wvalid_reg <= 1'b0;
            scr_waddr_reg  <= '0;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
            pend_reg       <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                def_attr_reg <= cfg_data;
            end
            // A new result loads the output register, else a taken one leaves it.
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            scr_wvalid_reg <= (state_reg == ST_SCROLL);

            unique case (state_reg)
                ST_CLEAR: begin
                    if (32'(cnt_reg) == CELL_COUNT - 1) begin
                        cnt_reg   <= '0;
                        state_reg <= ST_IDLE;
                    end else begin
                        cnt_reg <= cnt_reg + ADDR_W'(1);
                    end
                end
                ST_IDLE: begin
                    if (s_acc) begin
                        if (in_func == FN_APPEND && in_char != NEWLINE_CODE
                            && 32'(cur_row_reg) >= ROWS) begin
                            cnt_reg     <= '0;
                            cur_row_reg <= ROW_W'(ROWS - 1);
                            state_reg   <= ST_SCROLL;
                        end else begin
                            state_reg <= ST_EXEC;
                        end
                    end
                end
                ST_SCROLL: begin
                    // Read row below now, write it one row up next cycle.
                    scr_waddr_reg  <= cnt_reg;
                    cnt_reg        <= cnt_reg + ADDR_W'(1);
                    if (32'(cnt_reg) == SCROLL_LEN - 1) begin
                        state_reg <= ST_BLANK;
                    end
                end
                ST_BLANK: begin
                    // The last copy drains first; blanks then fill the last row.
                    if (!scr_wvalid_reg) begin
                        if (32'(cnt_reg) == CELL_COUNT - 1) begin
                            cnt_reg   <= '0;
                            state_reg <= ST_EXEC;
                        end else begin
                            cnt_reg <= cnt_reg + ADDR_W'(1);
                        end
                    end
                end
                ST_EXEC: begin
                    cur_col_reg <= nx_col;
                    cur_row_reg <= nx_row;
                    if (out_free) begin
                        out_reg       <= res;
                        state_reg     <= ST_IDLE;
                    end else begin
                        pend_reg  <= res;
                        state_reg <= ST_HOLD;
                    end
                end
                ST_HOLD: begin
                    if (out_free) begin
                        out_reg       <= pend_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // An accepted request goes straight to execution or to a scroll.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> (state_reg == ST_EXEC || state_reg == ST_SCROLL))
        else $error("accepted request did not start execution");

    // The cursor stays within the screen, one row past the end at most.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (32'(cur_col_reg) < COLUMNS) && (32'(cur_row_reg) <= ROWS))
        else $error("cursor out of range");

    // No cell is written while the engine waits for a request.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !mem_we)
        else $error("memory write while idle");

    // A scroll copy pipeline write never runs outside the scroll sequence.
    assert property (@(posedge aclk) disable iff (!aresetn)
        scr_wvalid_reg |-> (state_reg == ST_SCROLL || state_reg == ST_BLANK))
        else $error("stray scroll copy write");

    // A result without a cursor report carries a zero position.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_reg.upd) |-> (out_reg.pos == '0))
        else $error("position reported without cursor update");

endmodule
